// ===== hdl/quantized_depthwise_conv_mac_unit_assert.svh =====
// Assertion macros for the depthwise convolution MAC unit checker.
`ifndef QUANTIZED_DEPTHWISE_CONV_MAC_UNIT_ASSERT_SVH
`define QUANTIZED_DEPTHWISE_CONV_MAC_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define QDWC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define QDWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/qdwc_pkg.sv =====
// Shared types, codes and helpers for the depthwise convolution MAC unit.
`timescale 1ns / 1ps

package qdwc_pkg;

   localparam int VALUE_W     = 8;
   localparam int TAP_FIELD_W = 5;
   localparam int CH_FIELD_W  = 8;
   localparam int SUM_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_ACT    = 1'b1;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_INPUT_ZP      = 3'd0;
   localparam csr_index_type CSR_INPUT_SIGNED  = 3'd1;
   localparam csr_index_type CSR_FILTER_ZP     = 3'd2;
   localparam csr_index_type CSR_FILTER_SIGNED = 3'd3;
   localparam csr_index_type CSR_CHANNEL_COUNT = 3'd4;
   localparam csr_index_type CSR_TAP_COUNT     = 3'd5;

   // byte minus zero point: -255..255
   typedef logic signed [9:0]  diff_type;
   typedef logic signed [19:0] prod_type;

   typedef struct packed {
      logic first;
      logic emit;
      logic last;
   } stage_ctl_type;

   function automatic diff_type byte_diff(logic [7:0] b, logic [7:0] zp, logic sgn);
      diff_type bx;
      diff_type zx;
      bx = sgn ? {{2{b[7]}}, b} : {2'b00, b};
      zx = sgn ? {{2{zp[7]}}, zp} : {2'b00, zp};
      return bx - zx;
   endfunction

endpackage

// ===== hdl/qdwc_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module qdwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/quantized_depthwise_conv_mac_unit.sv =====
// Top level of the quantized depthwise convolution MAC unit.
`timescale 1ns / 1ps

// Usage
//  req_*: one item per transfer. req_func = FUNC_WEIGHT stores req_value at
//    (req_weight_tap, req_weight_channel) and restarts the channel and tap
//    positions; FUNC_ACT supplies the next activation, tap-major, channels
//    innermost. Load all weights before streaming activations.
//  rsp_*: one result per activation on the last tap: the wrapped 32-bit
//    channel sum, its channel, and last_in_vector on the last channel.
//  csr_*: register writes, always ready; write only while the unit is idle.
//  Throughput: one item per cycle while the result side keeps up. An activation
//    goes through three stages (weight/accumulator read, multiply, accumulate
//    and write back); its result is then registered onto rsp_valid.
//  Accumulators live in a RAM with registered read data; the last two
//    write-backs are forwarded so a channel can recur in consecutive cycles.
//  When rsp_ready is low, items that emit nothing still drain; up to two
//    activations are held behind the waiting result before req_ready drops.
//  Reset clears the positions, the pipeline and the registers to their
//    defaults; weight and accumulator RAM contents are kept.
module quantized_depthwise_conv_mac_unit #(
   parameter int MAX_CHANNELS = 256,
   parameter int MAX_TAPS     = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [qdwc_pkg::VALUE_W-1:0]         req_value,
   input  logic [qdwc_pkg::TAP_FIELD_W-1:0]     req_weight_tap,
   input  logic [qdwc_pkg::CH_FIELD_W-1:0]      req_weight_channel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [qdwc_pkg::SUM_W-1:0]    rsp_sum,
   output logic [qdwc_pkg::CH_FIELD_W-1:0]      rsp_channel,
   output logic                                 rsp_last_in_vector,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  qdwc_pkg::csr_index_type              csr_index,
   input  logic [qdwc_pkg::CSR_DATA_W-1:0]      csr_data
);

   import qdwc_pkg::*;

   localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int TAP_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CH_CNT_W  = $clog2(MAX_CHANNELS + 1);
   localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
   localparam int W_DEPTH   = MAX_TAPS * MAX_CHANNELS;
   localparam int W_AW      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;

   // configuration
   logic [7:0]           in_zp_ff;
   logic                 in_sgn_ff;
   logic [7:0]           f_zp_ff;
   logic                 f_sgn_ff;
   logic [CH_CNT_W-1:0]  nch_ff;
   logic [CH_CNT_W-1:0]  nch_in;
   logic [TAP_CNT_W-1:0] ntap_ff;
   logic [TAP_CNT_W-1:0] ntap_in;
   logic                 csr_xfer;

   // accept stage
   logic             req_xfer;
   logic             act_xfer;
   logic             wgt_xfer;
   logic             wgt_in_range;
   logic [CH_W-1:0]  ch_pos_ff;
   logic [CH_W-1:0]  ch_pos_in;
   logic [TAP_W-1:0] tap_pos_ff;
   logic [TAP_W-1:0] tap_pos_in;
   logic [CH_W-1:0]  cur_ch;
   logic [TAP_W-1:0] cur_tap;
   logic             ch_last;
   logic             tap_last;
   logic [W_AW-1:0]  wgt_wr_addr;
   logic [W_AW-1:0]  wgt_rd_addr;
   logic [7:0]       wgt_rd_data;

   // multiply stage
   logic          s1_valid_ff;
   logic          s1_valid_in;
   stage_ctl_type s1_ctl_ff;
   logic [CH_W-1:0] s1_ch_ff;
   diff_type      s1_x_ff;
   diff_type      s1_w;
   prod_type      s1_prod;
   logic          s1_adv;
   logic [SUM_W-1:0] acc_rd_data;

   // accumulate stage
   logic          s2_valid_ff;
   logic          s2_valid_in;
   stage_ctl_type s2_ctl_ff;
   logic [CH_W-1:0] s2_ch_ff;
   prod_type      s2_prod_ff;
   logic [SUM_W-1:0] s2_acc_ff;
   logic [SUM_W-1:0] s2_acc_old;
   logic [SUM_W-1:0] s2_sum;
   logic          s2_adv;
   logic          s2_free;

   // write-back forwarding
   logic             wb1_valid_ff;
   logic [CH_W-1:0]  wb1_ch_ff;
   logic [SUM_W-1:0] wb1_data_ff;
   logic             wb2_valid_ff;
   logic [CH_W-1:0]  wb2_ch_ff;
   logic [SUM_W-1:0] wb2_data_ff;

   // output register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic [CH_FIELD_W-1:0] rsp_channel_ff;
   logic             rsp_last_ff;
   logic             out_free;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      if (csr_data == '0) begin
         nch_in = CH_CNT_W'(1);
      end else if (32'(csr_data) > MAX_CHANNELS) begin
         nch_in = CH_CNT_W'(MAX_CHANNELS);
      end else begin
         nch_in = CH_CNT_W'(csr_data);
      end
      if (csr_data[5:0] == '0) begin
         ntap_in = TAP_CNT_W'(1);
      end else if (32'(csr_data[5:0]) > MAX_TAPS) begin
         ntap_in = TAP_CNT_W'(MAX_TAPS);
      end else begin
         ntap_in = TAP_CNT_W'(csr_data[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_zp_ff  <= '0;
         in_sgn_ff <= 1'b0;
         f_zp_ff   <= '0;
         f_sgn_ff  <= 1'b1;
         nch_ff    <= CH_CNT_W'(1);
         ntap_ff   <= TAP_CNT_W'(1);
      end else if (csr_xfer) begin
         case (csr_index)
            CSR_INPUT_ZP:      in_zp_ff  <= csr_data[7:0];
            CSR_INPUT_SIGNED:  in_sgn_ff <= csr_data[0];
            CSR_FILTER_ZP:     f_zp_ff   <= csr_data[7:0];
            CSR_FILTER_SIGNED: f_sgn_ff  <= csr_data[0];
            CSR_CHANNEL_COUNT: nch_ff    <= nch_in;
            CSR_TAP_COUNT:     ntap_ff   <= ntap_in;
            default: ;
         endcase
      end
   end

   // ---------------- accept stage ----------------
   assign req_xfer = req_valid && req_ready;
   assign act_xfer = req_xfer && (req_func == FUNC_ACT);
   assign wgt_xfer = req_xfer && (req_func == FUNC_WEIGHT);

   assign cur_ch   = (CH_CNT_W'(ch_pos_ff) >= nch_ff) ? '0 : ch_pos_ff;
   assign cur_tap  = (TAP_CNT_W'(tap_pos_ff) >= ntap_ff) ? '0 : tap_pos_ff;
   assign ch_last  = CH_CNT_W'(cur_ch) == (nch_ff - CH_CNT_W'(1));
   assign tap_last = TAP_CNT_W'(cur_tap) == (ntap_ff - TAP_CNT_W'(1));

   always_comb begin
      ch_pos_in  = ch_pos_ff;
      tap_pos_in = tap_pos_ff;
      if (wgt_xfer) begin
         ch_pos_in  = '0;
         tap_pos_in = '0;
      end else if (act_xfer) begin
         if (ch_last) begin
            ch_pos_in  = '0;
            tap_pos_in = tap_last ? '0 : cur_tap + TAP_W'(1);
         end else begin
            ch_pos_in  = cur_ch + CH_W'(1);
            tap_pos_in = cur_tap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_pos_ff  <= '0;
         tap_pos_ff <= '0;
      end else begin
         ch_pos_ff  <= ch_pos_in;
         tap_pos_ff <= tap_pos_in;
      end
   end

   assign wgt_in_range = (32'(req_weight_tap) < MAX_TAPS) &&
                         (32'(req_weight_channel) < MAX_CHANNELS);
   assign wgt_wr_addr  = W_AW'(req_weight_tap) * W_AW'(MAX_CHANNELS) +
                         W_AW'(req_weight_channel);
   assign wgt_rd_addr  = W_AW'(cur_tap) * W_AW'(MAX_CHANNELS) + W_AW'(cur_ch);

   qdwc_ram #(
      .WIDTH (8),
      .DEPTH (W_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wgt_xfer && wgt_in_range),
      .wr_addr (wgt_wr_addr),
      .wr_data (req_value),
      .rd_en   (act_xfer),
      .rd_addr (wgt_rd_addr),
      .rd_data (wgt_rd_data)
   );

   qdwc_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_CHANNELS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s2_adv),
      .wr_addr (s2_ch_ff),
      .wr_data (s2_sum),
      .rd_en   (act_xfer),
      .rd_addr (cur_ch),
      .rd_data (acc_rd_data)
   );

   // ---------------- flow control ----------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = s2_valid_ff && (!s2_ctl_ff.emit || out_free);
   assign s2_free   = !s2_valid_ff || s2_adv;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s1_adv;

   // ---------------- multiply stage ----------------
   assign s1_valid_in = act_xfer || (s1_valid_ff && !s1_adv);
   assign s1_w        = byte_diff(wgt_rd_data, f_zp_ff, f_sgn_ff);
   assign s1_prod     = s1_x_ff * s1_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (act_xfer) begin
         s1_ctl_ff <= '{first: (cur_tap == '0), emit: tap_last, last: ch_last};
         s1_ch_ff  <= cur_ch;
         s1_x_ff   <= byte_diff(req_value, in_zp_ff, in_sgn_ff);
      end
   end

   // ---------------- accumulate stage ----------------
   assign s2_valid_in = s1_adv || (s2_valid_ff && !s2_adv);

   always_comb begin
      if (wb1_valid_ff && (wb1_ch_ff == s2_ch_ff)) begin
         s2_acc_old = wb1_data_ff;
      end else if (wb2_valid_ff && (wb2_ch_ff == s2_ch_ff)) begin
         s2_acc_old = wb2_data_ff;
      end else begin
         s2_acc_old = s2_acc_ff;
      end
      if (s2_ctl_ff.first) begin
         s2_sum = SUM_W'(s2_prod_ff);
      end else begin
         s2_sum = s2_acc_old + SUM_W'(s2_prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         wb1_valid_ff <= 1'b0;
         wb2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (s2_adv) begin
            wb1_valid_ff <= 1'b1;
            wb2_valid_ff <= wb1_valid_ff;
         end
      end
      if (s1_adv) begin
         s2_ctl_ff  <= s1_ctl_ff;
         s2_ch_ff   <= s1_ch_ff;
         s2_prod_ff <= s1_prod;
         s2_acc_ff  <= acc_rd_data;
      end
      if (s2_adv) begin
         wb1_ch_ff   <= s2_ch_ff;
         wb1_data_ff <= s2_sum;
         wb2_ch_ff   <= wb1_ch_ff;
         wb2_data_ff <= wb1_data_ff;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s2_adv && s2_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s2_adv && s2_ctl_ff.emit) begin
         rsp_sum_ff     <= s2_sum;
         rsp_channel_ff <= CH_FIELD_W'(s2_ch_ff);
         rsp_last_ff    <= s2_ctl_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum            = rsp_sum_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_last_in_vector = rsp_last_ff;

endmodule

// ===== hdl/qdwc_checker.sv =====
// Port-level checker for the depthwise convolution MAC unit, bound to the top level.
`timescale 1ns / 1ps
`include "quantized_depthwise_conv_mac_unit_assert.svh"

module qdwc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sum,
   input logic [7:0]  rsp_channel,
   input logic        rsp_last_in_vector
);

   // a stalled result holds
   `QDWC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum) && $stable(rsp_channel) && $stable(rsp_last_in_vector), "rsp changed while stalled")

   // input backpressure only behind a stalled result
   `QDWC_ASSERT(a_ready_cause, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "req_ready low without a stalled rsp transfer")

   // reset empties the pipeline
   `QDWC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready, "pipeline not empty after reset")

   // a result stalled while the input is full is not dropped
   `QDWC_ASSERT(a_rsp_order, clock, reset, $past(rsp_valid && !rsp_ready && !req_ready) && !$past(reset) |-> rsp_valid, "result dropped under backpressure")

endmodule

bind quantized_depthwise_conv_mac_unit qdwc_checker u_qdwc_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the quantized depthwise convolution MAC unit.
`timescale 1ns / 1ps

module tb;
   import qdwc_pkg::*;

   localparam int MAX_CHANNELS = 256;
   localparam int MAX_TAPS     = 32;
   localparam int TARGET_ITEMS = 1850;
   localparam int QUIET_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PRINT_LIMIT  = 30;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_func = FUNC_WEIGHT;
   logic [VALUE_W-1:0]          req_value = '0;
   logic [TAP_FIELD_W-1:0]      req_weight_tap = '0;
   logic [CH_FIELD_W-1:0]       req_weight_channel = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [SUM_W-1:0]     rsp_sum;
   logic [CH_FIELD_W-1:0]       rsp_channel;
   logic                        rsp_last_in_vector;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   csr_index_type               csr_index = CSR_INPUT_ZP;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   typedef struct {
      logic signed [SUM_W-1:0] sum;
      logic [CH_FIELD_W-1:0]   channel;
      logic                    last;
   } channel_sum_type;

   class dwconv_scoreboard;
      logic [7:0]      weights [MAX_TAPS*MAX_CHANNELS];
      bit              weight_written [MAX_TAPS*MAX_CHANNELS];
      logic [31:0]     accums [MAX_CHANNELS];
      int unsigned     chan_pos;
      int unsigned     tap_pos;
      logic [7:0]      in_zp;
      logic            in_sgn;
      logic [7:0]      flt_zp;
      logic            flt_sgn;
      logic [8:0]      ch_cnt;
      logic [5:0]      tap_cnt;
      channel_sum_type expected_sums [$];
      int              errors;
      int              checked;
      int              loads;
      int              acts;

      function new();
         chan_pos = 0;
         tap_pos  = 0;
         in_zp    = 8'd0;
         in_sgn   = 1'b0;
         flt_zp   = 8'd0;
         flt_sgn  = 1'b1;
         ch_cnt   = 9'd1;
         tap_cnt  = 6'd1;
         errors   = 0;
         checked  = 0;
         loads    = 0;
         acts     = 0;
      endfunction

      function int unsigned channels_in_use();
         if (ch_cnt == 0) return 1;
         return (ch_cnt > MAX_CHANNELS) ? MAX_CHANNELS : ch_cnt;
      endfunction

      function int unsigned taps_in_use();
         if (tap_cnt == 0) return 1;
         return (tap_cnt > MAX_TAPS) ? MAX_TAPS : tap_cnt;
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction

      function int byte_val(logic [7:0] b, logic sgn);
         if (sgn) return int'($signed(b));
         return int'(b);
      endfunction

      function void write_reg(csr_index_type idx, logic [8:0] data);
         case (idx)
            CSR_INPUT_ZP:      in_zp   = data[7:0];
            CSR_INPUT_SIGNED:  in_sgn  = data[0];
            CSR_FILTER_ZP:     flt_zp  = data[7:0];
            CSR_FILTER_SIGNED: flt_sgn = data[0];
            CSR_CHANNEL_COUNT: ch_cnt  = data;
            CSR_TAP_COUNT:     tap_cnt = data[5:0];
            default: ;
         endcase
      endfunction

      // one accepted transfer on the request side
      function void note_item(logic func, logic [7:0] value, logic [4:0] wtap,
                              logic [7:0] wch);
         int unsigned     nch;
         int unsigned     ntap;
         int unsigned     c;
         int unsigned     t;
         int              x;
         int              w;
         logic [31:0]     prod;
         channel_sum_type e;
         if (func == FUNC_WEIGHT) begin
            weights[{wtap, wch}] = value;
            weight_written[{wtap, wch}] = 1'b1;
            chan_pos = 0;
            tap_pos  = 0;
            loads++;
            return;
         end
         acts++;
         nch  = channels_in_use();
         ntap = taps_in_use();
         c = (chan_pos >= nch) ? 0 : chan_pos;
         t = (tap_pos >= ntap) ? 0 : tap_pos;
         x = byte_val(value, in_sgn) - byte_val(in_zp, in_sgn);
         w = byte_val(weights[t*MAX_CHANNELS + c], flt_sgn) - byte_val(flt_zp, flt_sgn);
         prod = x * w;
         accums[c] = (t == 0) ? prod : accums[c] + prod;
         if (t == ntap - 1) begin
            e.sum     = accums[c];
            e.channel = c[7:0];
            e.last    = (c == nch - 1);
            expected_sums.push_back(e);
         end
         if (c + 1 >= nch) begin
            chan_pos = 0;
            tap_pos  = (t + 1 >= ntap) ? 0 : t + 1;
         end else begin
            chan_pos = c + 1;
            tap_pos  = t;
         end
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
      endtask

      task check_sum(logic signed [31:0] sum, logic [7:0] ch, logic last);
         channel_sum_type e;
         checked++;
         if (expected_sums.size() == 0) begin
            report($sformatf("result with none expected: sum=%0d ch=%0d last=%0b",
                             sum, ch, last));
            return;
         end
         e = expected_sums.pop_front();
         if (sum !== e.sum)
            report($sformatf("sum ch=%0d: got %0d, want %0d", e.channel, sum, e.sum));
         if (ch !== e.channel)
            report($sformatf("channel: got %0d, want %0d", ch, e.channel));
         if (last !== e.last)
            report($sformatf("last_in_vector ch=%0d: got %0b, want %0b",
                             e.channel, last, e.last));
      endtask
   endclass

   dwconv_scoreboard sb = new();

   int  cycles = 0;
   int  items_sent = 0;
   int  csr_writes = 0;
   int  phases = 0;
   int  stall_left = 0;
   bit  sender_idle_on = 1'b0;
   bit  receiver_stall_on = 1'b0;

   quantized_depthwise_conv_mac_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_value          (req_value),
      .req_weight_tap     (req_weight_tap),
      .req_weight_channel (req_weight_channel),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sum            (rsp_sum),
      .rsp_channel        (rsp_channel),
      .rsp_last_in_vector (rsp_last_in_vector),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d sums outstanding", cycles, sb.pending());
         $display("Verification failed");
         $finish;
      end
   end

   // result side: check transfers, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_sum(rsp_sum, rsp_channel, rsp_last_in_vector);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_stall_on && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(input logic f, input logic [7:0] v, input logic [4:0] t,
                            input logic [7:0] c);
      if (sender_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= f;
      req_value          <= v;
      req_weight_tap     <= t;
      req_weight_channel <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(f, v, t, c);
      items_sent++;
   endtask

   // tap and channel fields are don't-care for activations
   task automatic send_act(input logic [7:0] v);
      send_item(FUNC_ACT, v, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [8:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_writes++;
   endtask

   // hold off until every sum is back and the pipeline has drained
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int idx);
      int          nch_w;
      int          ntap_w;
      int unsigned nch;
      int unsigned ntap;
      int          n_act;
      bit          loaded;
      case (idx)
         0: begin nch_w = 256; ntap_w = 1;  end
         1: begin nch_w = 1;   ntap_w = 32; end
         2: begin nch_w = 511; ntap_w = 0;  end
         3: begin nch_w = 0;   ntap_w = 63; end
         default: begin
            nch_w  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            ntap_w = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            if ($urandom_range(0, 19) == 0) nch_w = 0;
            if ($urandom_range(0, 19) == 0) ntap_w = 0;
         end
      endcase
      settle();
      if (items_sent >= TARGET_ITEMS - QUIET_ITEMS) begin
         sender_idle_on    = 1'b0;
         receiver_stall_on = 1'b0;
      end else begin
         sender_idle_on    = $urandom_range(0, 3) != 0;
         receiver_stall_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 1)) write_csr(CSR_INPUT_ZP, 9'(pick_byte()));
      if ($urandom_range(0, 1)) write_csr(CSR_INPUT_SIGNED, 9'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_csr(CSR_FILTER_ZP, 9'(pick_byte()));
      if ($urandom_range(0, 1)) write_csr(CSR_FILTER_SIGNED, 9'($urandom_range(0, 1)));
      if (idx < 4 || $urandom_range(0, 3) != 0) begin
         write_csr(CSR_CHANNEL_COUNT, 9'(nch_w));
         write_csr(CSR_TAP_COUNT, 9'(ntap_w));
      end
      csr_valid <= 1'b0;
      phases++;
      nch  = sb.channels_in_use();
      ntap = sb.taps_in_use();
      loaded = 1'b0;
      for (int t = 0; t < ntap; t++) begin
         for (int c = 0; c < nch; c++) begin
            if (!sb.weight_written[t*MAX_CHANNELS + c] || $urandom_range(0, 3) == 0) begin
               send_item(FUNC_WEIGHT, pick_byte(), 5'(t), 8'(c));
               loaded = 1'b1;
            end
         end
      end
      if (!loaded)
         send_item(FUNC_WEIGHT, pick_byte(), 5'($urandom_range(0, ntap - 1)),
                   8'($urandom_range(0, nch - 1)));
      n_act = nch * ntap * ((idx < 4) ? 1 : $urandom_range(1, 3));
      if (idx >= 4 && $urandom_range(0, 3) == 0) n_act += $urandom_range(1, nch * ntap);
      for (int i = 0; i < n_act; i++) begin
         // stray weight load restarts the positions mid-vector
         if (idx >= 4 && $urandom_range(0, 49) == 0)
            send_item(FUNC_WEIGHT, pick_byte(), 5'($urandom_range(0, 31)),
                      8'($urandom_range(0, 255)));
         send_act(pick_byte());
      end
   endtask

   initial begin
      logic [7:0] dir_w [6];
      logic [7:0] dir_a [6];
      int         idx;
      dir_w = '{8'h80, 8'hFF, 8'h00, 8'h7F, 8'h01, 8'hFE};
      dir_a = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: unsigned activations, signed weights, one channel, one tap
      send_item(FUNC_WEIGHT, 8'h80, 5'd0, 8'd0);
      send_act(8'hFF);
      send_act(8'h00);
      send_act(8'h80);
      send_item(FUNC_WEIGHT, 8'h7F, 5'd0, 8'd0);
      send_act(8'hFF);
      settle();
      // zero counts act as one; signedness swapped
      write_csr(CSR_INPUT_ZP, 9'h0FF);
      write_csr(CSR_INPUT_SIGNED, 9'd1);
      write_csr(CSR_FILTER_ZP, 9'h080);
      write_csr(CSR_FILTER_SIGNED, 9'd0);
      write_csr(CSR_CHANNEL_COUNT, 9'd0);
      write_csr(CSR_TAP_COUNT, 9'd0);
      csr_valid <= 1'b0;
      send_act(8'h80);
      send_act(8'h7F);
      settle();
      write_csr(CSR_INPUT_SIGNED, 9'd0);
      write_csr(CSR_INPUT_ZP, 9'h080);
      write_csr(CSR_FILTER_SIGNED, 9'd1);
      write_csr(CSR_FILTER_ZP, 9'h07F);
      write_csr(CSR_CHANNEL_COUNT, 9'd3);
      write_csr(CSR_TAP_COUNT, 9'd2);
      csr_valid <= 1'b0;
      for (int t = 0; t < 2; t++)
         for (int c = 0; c < 3; c++)
            send_item(FUNC_WEIGHT, dir_w[t*3 + c], 5'(t), 8'(c));
      for (int i = 0; i < 6; i++) send_act(dir_a[i]);
      for (int i = 0; i < 4; i++) send_act(dir_a[5 - i]);
      // channel count lowered mid-vector: position past the count restarts
      settle();
      write_csr(CSR_CHANNEL_COUNT, 9'd1);
      csr_valid <= 1'b0;
      send_act(8'h80);

      idx = 0;
      while (items_sent < TARGET_ITEMS) begin
         run_phase(idx);
         idx++;
      end
      settle();

      $display("Ran %0d items (%0d weight loads, %0d activations) across %0d settings",
               items_sent, sb.loads, sb.acts, phases);
      $display("%0d register writes, %0d channel sums checked, %0d mismatches",
               csr_writes, sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/qdwc_pkg.sv
hdl/qdwc_ram.sv
hdl/quantized_depthwise_conv_mac_unit.sv
hdl/qdwc_checker.sv
tb/tb.sv
